@@ sv/psl_pkg.sv @@
// shared types, constants and helper functions of the connection limiter
`default_nettype none
package psl_pkg;

  localparam int unsigned TableEntriesDefault = 64;

  // entries compared per table row read
  localparam int unsigned Lanes = 8;
  localparam int unsigned LaneW = 3;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned VerdW   = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InW     = 32;
  localparam int unsigned OutW    = 40;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [VerdW-1:0] {
    VERD_ADMIT    = 3'd0,
    VERD_TOO_MANY = 3'd1,
    VERD_PER_IP   = 3'd2,
    VERD_FULL     = 3'd3,
    VERD_CLOSED   = 3'd4,
    VERD_UNKNOWN  = 3'd5
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL_LIMIT      = 1'b0,
    CFG_PER_SOURCE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_SCAN,
    CTL_DRAIN,
    CTL_COMMIT
  } ctl_state_e;

  typedef struct packed {
    logic valid;
    logic [AddrW-1:0] addr;
    logic [CountW-1:0] count;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clr;     // write an invalid entry to every lane of the row
    logic rd;      // read the row for the search
    logic load;    // capture the request and restart the search
    logic commit;  // update the table and present the result
  } psl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } psl_sts_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountW'(1);
  endfunction

  function automatic logic [CountW-1:0] sat_dec(input logic [CountW-1:0] v);
    sat_dec = (v == '0) ? v : v - CountW'(1);
  endfunction

  // lowest set lane
  function automatic logic [LaneW-1:0] first_lane(input logic [Lanes-1:0] v);
    logic [LaneW-1:0] idx;
    idx = '0;
    for (int i = Lanes - 1; i >= 0; i--) begin
      if (v[i]) idx = LaneW'(i);
    end
    first_lane = idx;
  endfunction

endpackage
`default_nettype wire

@@ sv/per_source_connection_limiter.sv @@
// top level of the per-source connection limiter
//
//  channel   direction  signals                         contents
//  s_axis    in         tvalid tready tdata tuser       one open/close request
//  m_axis    out        tvalid tready tdata             one verdict per request
//  cfg       in         valid ready index data          limit register writes
//
// an accepted request is scanned over all Rows rows, then drained and committed, Rows being
// ceil(TABLE_ENTRIES / 8): the entry table is a single-port memory read one
// row of 8 entries per cycle, and every row is searched for the source
// address and the lowest free entry before the single commit cycle
// after reset a clearing pass writes every row invalid before the
// first request is taken; limit writes are taken at any time
// a result waits in the output register while the next request is accepted
// and scanned; commit holds only while that register is full and m_axis_tready is low
`default_nettype none
module per_source_connection_limiter #(
  parameter int unsigned TABLE_ENTRIES = psl_pkg::TableEntriesDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // request in
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [psl_pkg::InW-1:0]       s_axis_tdata,   // [31:0] source_address
  input  wire                          s_axis_tuser,   // [0] mode: 0 open, 1 close
  // result out
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [psl_pkg::OutW-1:0]     m_axis_tdata,   // [2:0] verdict, [18:3] total_now,
                                                       // [34:19] source_now, zero pad
  // limit register writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [psl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [psl_pkg::CfgW-1:0]      cfg_data_i
);
  import psl_pkg::*;

  // table geometry: rows of eight entries
  localparam int unsigned Rows = (TABLE_ENTRIES + Lanes - 1) / Lanes;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;

  psl_cmd_t cmd;
  psl_sts_t sts;
  logic [RowW-1:0] row;

  // limit registers never stall
  assign cfg_ready_o = 1'b1;

  psl_ctrl #(
    .Rows (Rows),
    .RowW (RowW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .row_o      (row)
  );

  psl_dp #(
    .TableEntries (TABLE_ENTRIES),
    .Rows         (Rows),
    .RowW         (RowW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (row),
    .sts_o       (sts),
    .in_mode_i   (s_axis_tuser),
    .in_addr_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ sv/psl_ctrl.sv @@
// controller state machine: table clear, row scan and commit sequencing
`default_nettype none
module psl_ctrl #(
  parameter int unsigned Rows = 8,
  parameter int unsigned RowW = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  psl_pkg::psl_sts_t    sts_i,
  output psl_pkg::psl_cmd_t    cmd_o,
  output logic [RowW-1:0]      row_o
);
  import psl_pkg::*;

  ctl_state_e state_q, state_d;
  logic [RowW-1:0] row_q, row_d;
  logic last_row;

  assign last_row = (row_q == RowW'(Rows - 1));
  assign row_o    = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_CLEAR;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CTL_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (last_row) begin
          row_d   = '0;
          state_d = CTL_IDLE;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end
      CTL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          row_d      = '0;
          state_d    = CTL_SCAN;
        end
      end
      CTL_SCAN: begin
        cmd_o.rd = 1'b1;
        if (last_row) begin
          row_d   = '0;
          state_d = CTL_DRAIN;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end
      CTL_DRAIN: begin
        state_d = CTL_COMMIT;
      end
      CTL_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/psl_dp.sv @@
// datapath: entry table, row search, counters, limits and result register
`default_nettype none
module psl_dp #(
  parameter int unsigned TableEntries = psl_pkg::TableEntriesDefault,
  parameter int unsigned Rows         = 8,
  parameter int unsigned RowW         = 3
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  psl_pkg::psl_cmd_t            cmd_i,
  input  wire [RowW-1:0]               row_i,
  output psl_pkg::psl_sts_t            sts_o,
  input  wire                          in_mode_i,
  input  wire [psl_pkg::AddrW-1:0]     in_addr_i,
  input  wire                          cfg_we_i,
  input  wire [psl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [psl_pkg::CfgW-1:0]      cfg_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [psl_pkg::OutW-1:0]     out_data_o
);
  import psl_pkg::*;

  localparam int unsigned IdxW = RowW + LaneW;

  // entry table, one row of lanes per read
  entry_t tbl_q [Rows][Lanes];
  entry_t rd_q [Lanes];
  logic [RowW-1:0] rd_row_q;
  logic rd_vld_q;

  logic [RowW-1:0] wr_row;
  logic [Lanes-1:0] wr_en;
  entry_t wr_data;

  // captured request and search results
  logic mode_q;
  logic [AddrW-1:0] addr_q;
  logic hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [CountW-1:0] hit_cnt_q;

  logic [CountW-1:0] total_q, total_d;
  logic [CfgW-1:0] total_limit_q, per_source_limit_q;

  logic out_valid_q;
  logic [OutW-1:0] out_data_q;

  logic [Lanes-1:0] lane_hit, lane_free;
  logic [LaneW-1:0] hit_lane, free_lane;

  // commit results
  logic [IdxW-1:0] slot;
  logic slot_we;
  logic [CountW-1:0] src;
  logic entry_keep;
  verdict_e verdict;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      if (wr_en[l]) tbl_q[wr_row][l] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      for (int l = 0; l < Lanes; l++) begin
        rd_q[l] <= tbl_q[row_i][l];
      end
    end
    rd_row_q <= row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= cmd_i.rd;
  end

  // per-lane compare on the row just read; lanes past the table end never match
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      logic present;
      present = ({1'b0, rd_row_q, LaneW'(l)} < (IdxW + 1)'(TableEntries));
      lane_hit[l]  = present && rd_q[l].valid && (rd_q[l].addr == addr_q);
      lane_free[l] = present && !rd_q[l].valid;
    end
    hit_lane  = first_lane(lane_hit);
    free_lane = first_lane(lane_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!hit_q && |lane_hit)   hit_q  <= 1'b1;
      if (!free_q && |lane_free) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      addr_q <= in_addr_i;
    end
    if (rd_vld_q && !hit_q && |lane_hit) begin
      hit_idx_q <= {rd_row_q, hit_lane};
      hit_cnt_q <= rd_q[hit_lane].count;
    end
    if (rd_vld_q && !free_q && |lane_free) begin
      free_idx_q <= {rd_row_q, free_lane};
    end
  end

  // event update and verdict
  always_comb begin
    slot       = hit_idx_q;
    slot_we    = 1'b0;
    src        = '0;
    entry_keep = 1'b1;
    if (!mode_q) begin
      total_d = sat_inc(total_q);
      if (hit_q) begin
        slot_we = 1'b1;
        src     = sat_inc(hit_cnt_q);
      end else if (free_q) begin
        slot    = free_idx_q;
        slot_we = 1'b1;
        src     = CountW'(1);
      end
      if (total_limit_q != '0 && total_d > total_limit_q) begin
        verdict = VERD_TOO_MANY;
      end else if (!hit_q && !free_q) begin
        verdict = VERD_FULL;
      end else if (per_source_limit_q != '0 && src > per_source_limit_q) begin
        verdict = VERD_PER_IP;
      end else begin
        verdict = VERD_ADMIT;
      end
    end else begin
      total_d = sat_dec(total_q);
      if (hit_q) begin
        slot_we    = 1'b1;
        src        = sat_dec(hit_cnt_q);
        entry_keep = (src != '0);
        verdict    = VERD_CLOSED;
      end else begin
        verdict = VERD_UNKNOWN;
      end
    end
  end

  // write port: clearing sweep or single-entry commit
  always_comb begin
    if (cmd_i.clr) begin
      wr_row  = row_i;
      wr_en   = '1;
      wr_data = '0;
    end else begin
      wr_row  = slot[IdxW-1:LaneW];
      wr_en   = '0;
      wr_en[slot[LaneW-1:0]] = cmd_i.commit && slot_we;
      wr_data.valid = entry_keep;
      wr_data.addr  = addr_q;
      wr_data.count = src;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q            <= '0;
      total_limit_q      <= '0;
      per_source_limit_q <= '0;
    end else begin
      if (cmd_i.commit) total_q <= total_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TOTAL_LIMIT:      total_limit_q      <= cfg_data_i;
          CFG_PER_SOURCE_LIMIT: per_source_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {(OutW - VerdW - 2 * CountW)'(0), src, total_d, verdict};
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule
`default_nettype wire
